/* rtl/aavr_pkg.sv */
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared widths, constants and the arctangent table for the axis-angle rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

   localparam int AXIS_W     = 18;               // axis component, Q1.16
   localparam int CW         = 34;               // cordic x, y, z
   localparam int C_W        = 20;               // sine and cosine, Q.16
   localparam int UU_W       = 2 * AXIS_W;       // axis products, Q.32
   localparam int D_W        = C_W + UU_W + 1;   // second stage products
   localparam int US_W       = AXIS_W + C_W;     // axis times sine
   localparam int M_W        = 32;               // matrix entries, Q.24
   localparam int ATAN_ENTRIES = 24;

   localparam int VEC_WIDTH_DEF   = 24;
   localparam int ANGLE_BITS_DEF  = 16;
   localparam int TRIG_STAGES_DEF = 16;

   localparam logic signed [CW-1:0] TRIG_GAIN = CW'(652032874);

   function automatic logic signed [CW-1:0] atan_val(input int idx);
      logic signed [CW-1:0] r;
      begin
         case (idx)
            0:  r = CW'(536870912);
            1:  r = CW'(316933405);
            2:  r = CW'(167458907);
            3:  r = CW'(85004756);
            4:  r = CW'(42667331);
            5:  r = CW'(21354465);
            6:  r = CW'(10679830);
            7:  r = CW'(5340245);
            8:  r = CW'(2670163);
            9:  r = CW'(1335086);
            10: r = CW'(667544);
            11: r = CW'(333772);
            12: r = CW'(166886);
            13: r = CW'(83443);
            14: r = CW'(41721);
            15: r = CW'(20860);
            16: r = CW'(10430);
            17: r = CW'(5215);
            18: r = CW'(2607);
            19: r = CW'(1303);
            20: r = CW'(651);
            21: r = CW'(325);
            22: r = CW'(162);
            23: r = CW'(81);
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // add half an lsb, then arithmetic shift
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int s);
      logic signed [63:0] h;
      begin
         h = 64'sd1 <<< (s - 1);
         return (v + h) >>> s;
      end
   endfunction

endpackage

/* rtl/aavr_cordic_cell.sv */
// ----------------------------------------------------------------------------
// aavr_cordic_cell
// One rotation-mode cordic step; carries the word's other fields alongside.
// ----------------------------------------------------------------------------
module aavr_cordic_cell #(
   parameter int STAGE = 0,
   parameter int PAY_W = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            src_valid,
   input  logic signed [aavr_pkg::CW-1:0]  src_x,
   input  logic signed [aavr_pkg::CW-1:0]  src_y,
   input  logic signed [aavr_pkg::CW-1:0]  src_z,
   input  logic [PAY_W-1:0]                src_pay,
   output logic                            dst_valid,
   output logic signed [aavr_pkg::CW-1:0]  dst_x,
   output logic signed [aavr_pkg::CW-1:0]  dst_y,
   output logic signed [aavr_pkg::CW-1:0]  dst_z,
   output logic [PAY_W-1:0]                dst_pay
);
   import aavr_pkg::*;

   localparam logic signed [CW-1:0] ATAN = atan_val(STAGE);

   logic                 valid_ff;
   logic signed [CW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic [PAY_W-1:0]     pay_ff;
   logic signed [CW-1:0] xs, ys;

   always_comb begin
      xs = src_x >>> STAGE;
      ys = src_y >>> STAGE;
      if (!src_z[CW-1]) begin
         x_in = src_x - ys;
         y_in = src_y + xs;
         z_in = src_z - ATAN;
      end else begin
         x_in = src_x + ys;
         y_in = src_y - xs;
         z_in = src_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         pay_ff <= src_pay;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_x     = x_ff;
   assign dst_y     = y_ff;
   assign dst_z     = z_ff;
   assign dst_pay   = pay_ff;

endmodule

/* rtl/aavr_matrix.sv */
// ----------------------------------------------------------------------------
// aavr_matrix
// Three-stage build of the Rodrigues matrix from cosine, sine and the axis.
// ----------------------------------------------------------------------------
module aavr_matrix #(
   parameter int VEC_WIDTH = aavr_pkg::VEC_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               src_valid,
   input  logic signed [aavr_pkg::CW-1:0]     src_x,
   input  logic signed [aavr_pkg::CW-1:0]     src_y,
   input  logic                               src_flip,
   input  logic signed [aavr_pkg::AXIS_W-1:0] src_axis [3],
   input  logic signed [VEC_WIDTH-1:0]        src_vec [3],
   output logic                               dst_valid,
   output logic signed [aavr_pkg::M_W-1:0]    dst_mat [3][3],
   output logic signed [VEC_WIDTH-1:0]        dst_vec [3]
);
   import aavr_pkg::*;

   localparam logic signed [UU_W:0] ONE_Q32 = (UU_W+1)'(64'sd1 <<< 32);

   logic [2:0] valid_ff;

   // stage 1
   logic signed [C_W-1:0]    c1_ff, s1_ff, c1_in, s1_in;
   logic signed [UU_W-1:0]   sq1_ff [3];
   logic signed [UU_W-1:0]   cr1_ff [3];
   logic signed [AXIS_W-1:0] ax1_ff [3];
   logic signed [VEC_WIDTH-1:0] v1_ff [3];
   logic signed [CW-1:0]     xf, yf, xr, yr;

   // stage 2
   logic signed [D_W-1:0]    d2_ff [3];
   logic signed [D_W-1:0]    p2_ff [3];
   logic signed [US_W-1:0]   us2_ff [3];
   logic signed [UU_W-1:0]   sq2_ff [3];
   logic signed [VEC_WIDTH-1:0] v2_ff [3];
   logic signed [C_W:0]      omc;

   // stage 3
   logic signed [M_W-1:0]    m3_ff [3][3];
   logic signed [M_W-1:0]    m3_in [3][3];
   logic signed [VEC_WIDTH-1:0] v3_ff [3];
   logic signed [63:0]       pr [3];
   logic signed [63:0]       us [3];
   logic signed [63:0]       dg;

   always_comb begin
      xf = src_flip ? -src_x : src_x;
      yf = src_flip ? -src_y : src_y;
      xr = (xf + CW'(8192)) >>> 14;
      yr = (yf + CW'(8192)) >>> 14;
      c1_in = xr[C_W-1:0];
      s1_in = yr[C_W-1:0];
   end

   assign omc = (C_W+1)'(65536) - (C_W+1)'(c1_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pr[i] = rnd_shift(64'(p2_ff[i]), 16);
         us[i] = 64'(us2_ff[i]);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            m3_in[i][j] = '0;
         end
      end
      for (int i = 0; i < 3; i++) begin
         dg = 64'(sq2_ff[i]) + rnd_shift(64'(d2_ff[i]), 16);
         m3_in[i][i] = M_W'(rnd_shift(dg, 8));
      end
      // off-diagonal pairs share the (1-c) product, differ in the sine sign
      m3_in[0][1] = M_W'(rnd_shift(pr[0] - us[2], 8));
      m3_in[1][0] = M_W'(rnd_shift(pr[0] + us[2], 8));
      m3_in[0][2] = M_W'(rnd_shift(pr[1] + us[1], 8));
      m3_in[2][0] = M_W'(rnd_shift(pr[1] - us[1], 8));
      m3_in[1][2] = M_W'(rnd_shift(pr[2] - us[0], 8));
      m3_in[2][1] = M_W'(rnd_shift(pr[2] + us[0], 8));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], src_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff <= c1_in;
         s1_ff <= s1_in;
         for (int i = 0; i < 3; i++) begin
            sq1_ff[i] <= UU_W'(src_axis[i]) * UU_W'(src_axis[i]);
            ax1_ff[i] <= src_axis[i];
            v1_ff[i]  <= src_vec[i];
         end
         cr1_ff[0] <= UU_W'(src_axis[0]) * UU_W'(src_axis[1]);
         cr1_ff[1] <= UU_W'(src_axis[0]) * UU_W'(src_axis[2]);
         cr1_ff[2] <= UU_W'(src_axis[1]) * UU_W'(src_axis[2]);

         for (int i = 0; i < 3; i++) begin
            d2_ff[i]  <= D_W'((UU_W+1)'(ONE_Q32 - (UU_W+1)'(sq1_ff[i]))) * D_W'(c1_ff);
            p2_ff[i]  <= D_W'(cr1_ff[i]) * D_W'(omc);
            us2_ff[i] <= US_W'(ax1_ff[i]) * US_W'(s1_ff);
            sq2_ff[i] <= sq1_ff[i];
            v2_ff[i]  <= v1_ff[i];
         end

         m3_ff <= m3_in;
         v3_ff <= v2_ff;
      end
   end

   assign dst_valid = valid_ff[2];
   assign dst_mat   = m3_ff;
   assign dst_vec   = v3_ff;

endmodule

/* rtl/aavr_mac.sv */
// ----------------------------------------------------------------------------
// aavr_mac
// Matrix times vector: nine products, then row sums rounded and clipped.
// ----------------------------------------------------------------------------
module aavr_mac #(
   parameter int VEC_WIDTH = aavr_pkg::VEC_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            src_valid,
   input  logic signed [aavr_pkg::M_W-1:0] src_mat [3][3],
   input  logic signed [VEC_WIDTH-1:0]     src_vec [3],
   output logic                            dst_valid,
   output logic signed [VEC_WIDTH-1:0]     dst_rot [3],
   output logic                            dst_sat
);
   import aavr_pkg::*;

   localparam int PW    = M_W + VEC_WIDTH;
   localparam int ACC_W = PW + 2;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< 23);
   localparam logic signed [ACC_W-1:0] HI   = ACC_W'((64'sd1 <<< (VEC_WIDTH-1)) - 1);
   localparam logic signed [ACC_W-1:0] LO   = ACC_W'(-(64'sd1 <<< (VEC_WIDTH-1)));

   logic [1:0]                 valid_ff;
   logic signed [PW-1:0]        prod_ff [3][3];
   logic signed [VEC_WIDTH-1:0] rot_ff [3], rot_in [3];
   logic                        sat_ff, sat_in;
   logic signed [ACC_W-1:0]     acc, res;

   always_comb begin
      sat_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         acc = ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1]) + ACC_W'(prod_ff[r][2]);
         res = (acc + HALF) >>> 24;
         if (res > HI) begin
            rot_in[r] = HI[VEC_WIDTH-1:0];
            sat_in    = 1'b1;
         end else if (res < LO) begin
            rot_in[r] = LO[VEC_WIDTH-1:0];
            sat_in    = 1'b1;
         end else begin
            rot_in[r] = res[VEC_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[0], src_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[r][k] <= PW'(src_mat[r][k]) * PW'(src_vec[k]);
            end
         end
         rot_ff <= rot_in;
         sat_ff <= sat_in;
      end
   end

   assign dst_valid = valid_ff[1];
   assign dst_rot   = rot_ff;
   assign dst_sat   = sat_ff;

endmodule

/* rtl/axis_angle_vector_rotate.sv */
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate
// Rotates a fixed-point 3D vector about a unit axis by a binary angle.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word carries the vector (Q7.16), the axis (Q1.16) and
//   the angle (2^(ANGLE_BITS-1) is pi). rsp_ channel: one word with the
//   rotated vector, clipped to range, and a flag set when any part clipped.
//   Items are independent; one word can enter every cycle unless the output
//   stalls. A word passes the cordic cells of the sine/cosine chain, then the
//   matrix build, then the multiply and row sum. Throughput is one word per
//   cycle when no stall holds the pipeline.
//   The whole pipeline moves together; when the result register holds a
//   word that rsp_ready does not take, every stage holds and req_ready drops
//   in the same cycle. It rises again as soon as the word is taken.
//   Reset clears all valid flags; the pipeline then starts empty.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate #(
   parameter int VEC_WIDTH   = aavr_pkg::VEC_WIDTH_DEF,
   parameter int ANGLE_BITS  = aavr_pkg::ANGLE_BITS_DEF,
   parameter int TRIG_STAGES = aavr_pkg::TRIG_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [VEC_WIDTH-1:0]        req_vec_x,
   input  logic signed [VEC_WIDTH-1:0]        req_vec_y,
   input  logic signed [VEC_WIDTH-1:0]        req_vec_z,
   input  logic signed [aavr_pkg::AXIS_W-1:0] req_axis_x,
   input  logic signed [aavr_pkg::AXIS_W-1:0] req_axis_y,
   input  logic signed [aavr_pkg::AXIS_W-1:0] req_axis_z,
   input  logic signed [ANGLE_BITS-1:0]       req_turn_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [VEC_WIDTH-1:0]        rsp_rot_x,
   output logic signed [VEC_WIDTH-1:0]        rsp_rot_y,
   output logic signed [VEC_WIDTH-1:0]        rsp_rot_z,
   output logic                               rsp_saturated
);
   import aavr_pkg::*;

   localparam int PAY_W = 3 * VEC_WIDTH + 3 * AXIS_W + 1;

   logic                 adv;
   logic [31:0]          phase;
   logic                 flip;
   logic [31:0]          zph;

   logic                 ch_valid [TRIG_STAGES+1];
   logic signed [CW-1:0] ch_x [TRIG_STAGES+1];
   logic signed [CW-1:0] ch_y [TRIG_STAGES+1];
   logic signed [CW-1:0] ch_z [TRIG_STAGES+1];
   logic [PAY_W-1:0]     ch_pay [TRIG_STAGES+1];

   logic [PAY_W-1:0]             tail;
   logic signed [AXIS_W-1:0]     t_axis [3];
   logic signed [VEC_WIDTH-1:0]  t_vec [3];
   logic                         mx_valid;
   logic signed [M_W-1:0]        mx_mat [3][3];
   logic signed [VEC_WIDTH-1:0]  mx_vec [3];
   logic signed [VEC_WIDTH-1:0]  rot [3];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // fold the second and third quadrants onto the first and fourth
   assign phase = {req_turn_angle, {(32 - ANGLE_BITS){1'b0}}};
   assign flip  = phase[31] ^ phase[30];
   assign zph   = {phase[31] ^ flip, phase[30:0]};

   assign ch_valid[0] = req_valid;
   assign ch_x[0]     = TRIG_GAIN;
   assign ch_y[0]     = '0;
   assign ch_z[0]     = CW'($signed(zph));
   assign ch_pay[0]   = {flip, req_axis_z, req_axis_y, req_axis_x,
                         req_vec_z, req_vec_y, req_vec_x};

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
      aavr_cordic_cell #(
         .STAGE (i),
         .PAY_W (PAY_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .src_valid (ch_valid[i]),
         .src_x     (ch_x[i]),
         .src_y     (ch_y[i]),
         .src_z     (ch_z[i]),
         .src_pay   (ch_pay[i]),
         .dst_valid (ch_valid[i+1]),
         .dst_x     (ch_x[i+1]),
         .dst_y     (ch_y[i+1]),
         .dst_z     (ch_z[i+1]),
         .dst_pay   (ch_pay[i+1])
      );
   end

   assign tail = ch_pay[TRIG_STAGES];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         t_vec[k]  = tail[k*VEC_WIDTH +: VEC_WIDTH];
         t_axis[k] = tail[3*VEC_WIDTH + k*AXIS_W +: AXIS_W];
      end
   end

   aavr_matrix #(
      .VEC_WIDTH (VEC_WIDTH)
   ) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .src_valid (ch_valid[TRIG_STAGES]),
      .src_x     (ch_x[TRIG_STAGES]),
      .src_y     (ch_y[TRIG_STAGES]),
      .src_flip  (tail[PAY_W-1]),
      .src_axis  (t_axis),
      .src_vec   (t_vec),
      .dst_valid (mx_valid),
      .dst_mat   (mx_mat),
      .dst_vec   (mx_vec)
   );

   aavr_mac #(
      .VEC_WIDTH (VEC_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .src_valid (mx_valid),
      .src_mat   (mx_mat),
      .src_vec   (mx_vec),
      .dst_valid (rsp_valid),
      .dst_rot   (rot),
      .dst_sat   (rsp_saturated)
   );

   assign rsp_rot_x = rot[0];
   assign rsp_rot_y = rot[1];
   assign rsp_rot_z = rot[2];

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_sat_means_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_rot_x == {1'b0, {(VEC_WIDTH-1){1'b1}}}) ||
         (rsp_rot_x == {1'b1, {(VEC_WIDTH-1){1'b0}}}) ||
         (rsp_rot_y == {1'b0, {(VEC_WIDTH-1){1'b1}}}) ||
         (rsp_rot_y == {1'b1, {(VEC_WIDTH-1){1'b0}}}) ||
         (rsp_rot_z == {1'b0, {(VEC_WIDTH-1){1'b1}}}) ||
         (rsp_rot_z == {1'b1, {(VEC_WIDTH-1){1'b0}}}))
      else $error("saturated flag without a clipped component");

endmodule

/* dv/tb_axis_angle_vector_rotate.sv */
// ----------------------------------------------------------------------------
// tb_axis_angle_vector_rotate
// Self-checking bench for the axis-angle rotator: a directed table, then
// random words, each checked against a fixed-point Rodrigues predictor with
// random idle cycles on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_axis_angle_vector_rotate;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW       = aavr_pkg::VEC_WIDTH_DEF;
   localparam int AW       = aavr_pkg::AXIS_W;
   localparam int NUM_RAND = 1200;
   localparam int WD_LIMIT = 3000;
   localparam int HOLD_AT  = 500;
   localparam int HOLD_LEN = 300;

   typedef struct {
      logic signed [VW-1:0] vec_x, vec_y, vec_z;
      logic signed [AW-1:0] axis_x, axis_y, axis_z;
      logic signed [15:0]   turn_angle;
      bit                   typed;
      logic signed [VW-1:0] rot_x, rot_y, rot_z;
      logic                 saturated;
   } word_type;

   typedef struct {
      logic signed [VW-1:0] rot_x, rot_y, rot_z;
      logic                 saturated;
   } rotated_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [VW-1:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic signed [AW-1:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic signed [15:0]   req_turn_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [VW-1:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic rsp_saturated;

   word_type    stim_q[$];
   rotated_type rotated_q[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          words_out = 0;
   int          words_in = 0;
   bit          stim_done = 1'b0;

   always #5 clock = ~clock;

   axis_angle_vector_rotate u_top (.*);

   // ---------------------------------------------------------------- predictor
   localparam longint ATAN_PH[16] = '{
      536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
      10679830, 5340245, 2670163, 1335086, 667544, 333772,
      166886, 83443, 41721, 20860
   };

   function automatic longint round_by(input longint v, input int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic void sine_cosine(input logic [15:0] ang,
                                       output longint cs, output longint sn);
      logic [31:0] ph;
      longint x, y, z, xs, ys;
      bit flip;
      ph = {ang, 16'h0};
      flip = ph[31] ^ ph[30];
      if (flip) ph[31] = ~ph[31];
      z = longint'($signed(ph));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ATAN_PH[i];
         end else begin
            x = x + ys; y = y - xs; z = z + ATAN_PH[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      cs = round_by(x, 14);
      sn = round_by(y, 14);
   endfunction

   function automatic longint diag_term(input longint uu, input longint cs);
      return round_by(uu + round_by(cs * ((longint'(1) <<< 32) - uu), 16), 8);
   endfunction

   function automatic rotated_type rotate_vector(input word_type w);
      longint v[3], ux, uy, uz, cs, sn, omc, pxy, pxz, pyz, acc, res;
      longint m[3][3];
      longint hi, lo;
      rotated_type r;
      v[0] = longint'(w.vec_x); v[1] = longint'(w.vec_y); v[2] = longint'(w.vec_z);
      ux = longint'(w.axis_x); uy = longint'(w.axis_y); uz = longint'(w.axis_z);
      sine_cosine(w.turn_angle, cs, sn);
      omc = 65536 - cs;
      m[0][0] = diag_term(ux * ux, cs);
      m[1][1] = diag_term(uy * uy, cs);
      m[2][2] = diag_term(uz * uz, cs);
      pxy = round_by(ux * uy * omc, 16);
      pxz = round_by(ux * uz * omc, 16);
      pyz = round_by(uy * uz * omc, 16);
      m[0][1] = round_by(pxy - uz * sn, 8);
      m[1][0] = round_by(pxy + uz * sn, 8);
      m[0][2] = round_by(pxz + uy * sn, 8);
      m[2][0] = round_by(pxz - uy * sn, 8);
      m[1][2] = round_by(pyz - ux * sn, 8);
      m[2][1] = round_by(pyz + ux * sn, 8);
      hi = (longint'(1) <<< (VW - 1)) - 1;
      lo = -(longint'(1) <<< (VW - 1));
      r.saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
         res = round_by(acc, 24);
         if (res > hi) begin res = hi; r.saturated = 1'b1; end
         if (res < lo) begin res = lo; r.saturated = 1'b1; end
         case (i)
            0: r.rot_x = res[VW-1:0];
            1: r.rot_y = res[VW-1:0];
            default: r.rot_z = res[VW-1:0];
         endcase
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus
   task automatic add_row(input int vx, vy, vz, ax, ay, az, ang, input bit zero_out);
      word_type w;
      w.vec_x = VW'(vx); w.vec_y = VW'(vy); w.vec_z = VW'(vz);
      w.axis_x = AW'(ax); w.axis_y = AW'(ay); w.axis_z = AW'(az);
      w.turn_angle = 16'(ang);
      // a zero vector rotates to zero, so the answer is known outright
      w.typed = zero_out;
      w.rot_x = '0; w.rot_y = '0; w.rot_z = '0; w.saturated = 1'b0;
      stim_q.push_back(w);
   endtask

   function automatic int axis_comp(input real a, input real n);
      return $rtoi(a / n * 65536.0);
   endfunction

   task automatic add_random_row();
      int vx, vy, vz, ax, ay, az, pick;
      real a, b, c, n;
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) begin
         vx = $urandom; vy = $urandom; vz = $urandom;
      end else begin
         vx = $urandom_range(0, 262143) - 131072;
         vy = $urandom_range(0, 262143) - 131072;
         vz = $urandom_range(0, 262143) - 131072;
      end
      if (pick < 6) begin
         a = $urandom_range(0, 2000) - 1000.0;
         b = $urandom_range(0, 2000) - 1000.0;
         c = $urandom_range(0, 2000) - 1000.0;
         n = $sqrt(a * a + b * b + c * c);
         if (n < 1.0) begin a = 1.0; n = 1.0; end
         ax = axis_comp(a, n); ay = axis_comp(b, n); az = axis_comp(c, n);
      end else if (pick < 8) begin
         ax = $urandom_range(0, 131072) - 65536;
         ay = $urandom_range(0, 131072) - 65536;
         az = $urandom_range(0, 131072) - 65536;
      end else if (pick == 8) begin
         ax = 0; ay = 0; az = 0;
      end else begin
         ax = 0; ay = 0; az = 0;
         case ($urandom_range(0, 2))
            0: ax = $urandom_range(0, 1) ? 65536 : -65536;
            1: ay = $urandom_range(0, 1) ? 65536 : -65536;
            default: az = $urandom_range(0, 1) ? 65536 : -65536;
         endcase
      end
      add_row(vx, vy, vz, ax, ay, az, $urandom_range(0, 65535), 1'b0);
   endtask

   initial begin
      // directed table
      add_row( 8388607,  8388607,  8388607,      0,      0,      0,      0, 1'b0);
      add_row(-8388608, -8388608, -8388608,      0,      0,      0, -32768, 1'b0);
      add_row(   65536,        0,        0,  65536,      0,      0,      0, 1'b0);
      add_row(       0,    65536,        0,  65536,      0,      0,  16384, 1'b0);
      add_row(       0,    65536,        0,  65536,      0,      0, -16384, 1'b0);
      add_row(       0,        0,    65536,  65536,      0,      0, -32768, 1'b0);
      add_row(       0,        0,    65536,  65536,      0,      0,  32767, 1'b0);
      add_row(   65536,    65536,    65536, -65536,      0,      0,   8192, 1'b0);
      add_row(   65536,    65536,    65536,      0,  65536,      0,  16383, 1'b0);
      add_row(   65536,    65536,    65536,      0, -65536,      0,  16385, 1'b0);
      add_row(   65536,    65536,    65536,      0,      0,  65536, -16383, 1'b0);
      add_row(   65536,    65536,    65536,      0,      0, -65536, -16385, 1'b0);
      add_row( 8388607,  8388607,  8388607,  65536,  65536,  65536,      0, 1'b0);
      add_row(-8388608, -8388608, -8388608, -65536, -65536, -65536,  12345, 1'b0);
      add_row( 8388607, -8388608,  8388607,  65536,      0,      0,  16384, 1'b0);
      add_row(-8388608,  8388607, -8388608,      0,      0,  65536, -32768, 1'b0);
      add_row( 8388607,  8388607,        0,  37837,  37837,  37837,  21845, 1'b0);
      add_row(       1,       -1,        1,  46341,  46341,      0,     -1, 1'b0);
      add_row( 8388607,  8388607,  8388607,  65536,  65536,  65536,  32767, 1'b0);
      add_row(       0,        0,        0,  65536,  65536,  65536,   1000, 1'b1);
      for (int i = 0; i < NUM_RAND; i++) add_random_row();
   end

   // ---------------------------------------------------------------- drivers
   task automatic drive_word(input word_type w);
      req_valid      <= 1'b1;
      req_vec_x      <= w.vec_x;
      req_vec_y      <= w.vec_y;
      req_vec_z      <= w.vec_z;
      req_axis_x     <= w.axis_x;
      req_axis_y     <= w.axis_y;
      req_axis_z     <= w.axis_z;
      req_turn_angle <= w.turn_angle;
   endtask

   function automatic int draw_gap(input int count);
      // every fourth stretch of 150 words runs back to back
      return ((count / 150) % 4 == 1) ? 0 : $urandom_range(0, 17);
   endfunction

   initial begin
      word_type w;
      rotated_type r;
      int gap;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (stim_q.size() != 0) begin
         gap = draw_gap(words_in);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         w = stim_q.pop_front();
         drive_word(w);
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         if (w.typed) begin
            r.rot_x = w.rot_x; r.rot_y = w.rot_y; r.rot_z = w.rot_z;
            r.saturated = w.saturated;
         end else begin
            r = rotate_vector(w);
         end
         rotated_q.push_back(r);
         words_in++;
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (words_out == HOLD_AT) gap = HOLD_LEN;
         else gap = ((words_out / 130) % 4 == 2) ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         words_out++;
      end
   end

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, words_out);
      errors++;
   endtask

   always @(posedge clock) begin
      rotated_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rotated_q.size() == 0) begin
            $display("unexpected word out (word %0d)", words_out);
            errors++;
         end else begin
            r = rotated_q.pop_front();
            if (rsp_rot_x !== r.rot_x) report_mismatch("rot_x", rsp_rot_x, r.rot_x);
            if (rsp_rot_y !== r.rot_y) report_mismatch("rot_y", rsp_rot_y, r.rot_y);
            if (rsp_rot_z !== r.rot_z) report_mismatch("rot_z", rsp_rot_z, r.rot_z);
            if (rsp_saturated !== r.saturated)
               report_mismatch("saturated", rsp_saturated, r.saturated);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("timeout: no progress for %0d cycles", WD_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (rotated_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
